>>> rtl/core/spherical_to_cartesian_state_top_defines.svh
// Assertion macros shared by the checker
`ifndef SPHERICAL_TO_CARTESIAN_STATE_TOP_DEFINES_SVH
`define SPHERICAL_TO_CARTESIAN_STATE_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define S2C_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("s2c check failed");
// Next-cycle implication checked outside reset
`define S2C_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("s2c check failed");
`endif

>>> rtl/core/s2c_pkg.sv
`timescale 1ns / 1ps
package s2c_pkg;
  // CORDIC iterations and start gain in Q2.30
  localparam int CordicSteps = 20;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [33:0] HalfPi = 34'sd1073741824;
  localparam logic signed [33:0] Pi = 34'sd2147483648;

  // Arc table in units of 2^-31 pi
  function automatic logic signed [33:0] arc_at(input int i);
    logic signed [33:0] v;
    case (i)
      0: v = 34'sd536870912;
      1: v = 34'sd316933406;
      2: v = 34'sd167458907;
      3: v = 34'sd85004756;
      4: v = 34'sd42667331;
      5: v = 34'sd21354465;
      6: v = 34'sd10679838;
      7: v = 34'sd5340245;
      8: v = 34'sd2670163;
      9: v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Sine and cosine of one angle, Q1.15
  typedef struct packed {
    logic signed [16:0] s;
    logic signed [16:0] c;
  } trig_t;
endpackage

>>> rtl/core/s2c_cordic.sv
`timescale 1ns / 1ps
// Pipelined CORDIC: one register stage per rotation, stalls with en
module s2c_cordic import s2c_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output trig_t                        trig
);
  logic signed [33:0] x [0:CordicSteps];
  logic signed [33:0] y [0:CordicSteps];
  logic signed [33:0] z [0:CordicSteps];
  logic               flip [0:CordicSteps];
  logic signed [33:0] z0;
  logic signed [33:0] xr;
  logic signed [33:0] yr;
  logic signed [17:0] xc;
  logic signed [17:0] yc;

  // Fold the phase into +-pi/2
  always_comb begin
    z0 = 34'(signed'(angle)) <<< (32 - ANGLE_BITS);
    if (z0 > HalfPi) begin
      z[0] = z0 - Pi;
      flip[0] = 1'b1;
    end else if (z0 < -HalfPi) begin
      z[0] = z0 + Pi;
      flip[0] = 1'b1;
    end else begin
      z[0] = z0;
      flip[0] = 1'b0;
    end
    x[0] = CordicGain;
    y[0] = '0;
  end

  // Rotate one step per stage
  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        flip[i+1] <= flip[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - arc_at(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + arc_at(i);
        end
      end
    end
  end

  // Round to Q1.15, clamp, undo the fold
  always_comb begin
    xr = (x[CordicSteps] + 34'sd16384) >>> 15;
    yr = (y[CordicSteps] + 34'sd16384) >>> 15;
    xc = (xr > 34'sd32767) ? 18'sd32767 : (xr < -34'sd32767) ? -18'sd32767 : 18'(xr);
    yc = (yr > 34'sd32767) ? 18'sd32767 : (yr < -34'sd32767) ? -18'sd32767 : 18'(yr);
    trig.c = flip[CordicSteps] ? 17'(-xc) : 17'(xc);
    trig.s = flip[CordicSteps] ? 17'(-yc) : 17'(yc);
  end
endmodule

>>> rtl/core/s2c_math.sv
`timescale 1ns / 1ps
// Product pipeline: direction terms, then scale by radius and speed
module s2c_math import s2c_pkg::*; #(
  parameter int RADIUS_BITS = 31,
  parameter int SPEED_BITS  = 23
) (
  input  logic                         clk,
  input  logic                         en,
  input  trig_t                        tt,
  input  trig_t                        td,
  input  trig_t                        tg,
  input  trig_t                        tc,
  input  logic [RADIUS_BITS-1:0]       radius,
  input  logic [SPEED_BITS-1:0]        speed,
  output logic signed [RADIUS_BITS:0]  pos_x,
  output logic signed [RADIUS_BITS:0]  pos_y,
  output logic signed [RADIUS_BITS:0]  pos_z,
  output logic signed [SPEED_BITS:0]   vel_x,
  output logic signed [SPEED_BITS:0]   vel_y,
  output logic signed [SPEED_BITS:0]   vel_z
);
  localparam int PW = RADIUS_BITS + 20;
  localparam int VW = SPEED_BITS + 20;

  function automatic logic signed [17:0] r15(input logic signed [35:0] v);
    logic signed [35:0] t;
    t = (v + 36'sd16384) >>> 15;
    return 18'(t);
  endfunction

  // Stage 1 registers
  trig_t s1_t, s1_d;
  logic signed [17:0] s1_cdct, s1_cdst, s1_n, s1_e, s1_sg;
  logic [RADIUS_BITS-1:0] s1_r;
  logic [SPEED_BITS-1:0]  s1_v;
  // Stage 2
  trig_t s2_t, s2_d;
  logic signed [17:0] s2_cdct, s2_cdst, s2_e, s2_a, s2_dz;
  logic [RADIUS_BITS-1:0] s2_r;
  logic [SPEED_BITS-1:0]  s2_v;
  // Stage 3
  logic signed [17:0] s3_dx, s3_dy, s3_dz, s3_cdct, s3_cdst, s3_sd;
  logic [RADIUS_BITS-1:0] s3_r;
  logic [SPEED_BITS-1:0]  s3_v;
  // Stage 4 full products
  logic signed [PW-1:0] s4_px, s4_py, s4_pz;
  logic signed [VW-1:0] s4_vx, s4_vy, s4_vz;
  logic signed [PW-1:0] rpx, rpy, rpz;
  logic signed [VW-1:0] rvx, rvy, rvz;

  function automatic logic signed [RADIUS_BITS:0] satp(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] hi, lo;
    hi = PW'({1'b0, {RADIUS_BITS{1'b1}}});
    lo = -hi - PW'(1);
    if (v > hi) return {1'b0, {RADIUS_BITS{1'b1}}};
    if (v < lo) return {1'b1, {RADIUS_BITS{1'b0}}};
    return v[RADIUS_BITS:0];
  endfunction

  function automatic logic signed [SPEED_BITS:0] satv(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] hi, lo;
    hi = VW'({1'b0, {SPEED_BITS{1'b1}}});
    lo = -hi - VW'(1);
    if (v > hi) return {1'b0, {SPEED_BITS{1'b1}}};
    if (v < lo) return {1'b1, {SPEED_BITS{1'b0}}};
    return v[SPEED_BITS:0];
  endfunction

  // Advance all product stages together
  always_ff @(posedge clk) begin
    if (en) begin
      s1_t <= tt;
      s1_d <= td;
      s1_sg <= 18'(tg.s);
      s1_cdct <= r15(36'(td.c * tt.c));
      s1_cdst <= r15(36'(td.c * tt.s));
      s1_n <= r15(36'(tg.c * tc.c));
      s1_e <= r15(36'(tg.c * tc.s));
      s1_r <= radius;
      s1_v <= speed;

      s2_t <= s1_t;
      s2_d <= s1_d;
      s2_cdct <= s1_cdct;
      s2_cdst <= s1_cdst;
      s2_e <= s1_e;
      s2_a <= r15(36'(s1_sg * s1_d.c) - 36'(s1_n * s1_d.s));
      s2_dz <= r15(36'(s1_n * s1_d.c) + 36'(s1_sg * s1_d.s));
      s2_r <= s1_r;
      s2_v <= s1_v;

      s3_dx <= r15(36'(s2_a * s2_t.c) - 36'(s2_e * s2_t.s));
      s3_dy <= r15(36'(s2_a * s2_t.s) + 36'(s2_e * s2_t.c));
      s3_dz <= s2_dz;
      s3_cdct <= s2_cdct;
      s3_cdst <= s2_cdst;
      s3_sd <= 18'(s2_d.s);
      s3_r <= s2_r;
      s3_v <= s2_v;

      s4_px <= PW'($signed({1'b0, s3_r})) * PW'(s3_cdct);
      s4_py <= PW'($signed({1'b0, s3_r})) * PW'(s3_cdst);
      s4_pz <= PW'($signed({1'b0, s3_r})) * PW'(s3_sd);
      s4_vx <= VW'($signed({1'b0, s3_v})) * VW'(s3_dx);
      s4_vy <= VW'($signed({1'b0, s3_v})) * VW'(s3_dy);
      s4_vz <= VW'($signed({1'b0, s3_v})) * VW'(s3_dz);

      pos_x <= satp(rpx);
      pos_y <= satp(rpy);
      pos_z <= satp(rpz);
      vel_x <= satv(rvx);
      vel_y <= satv(rvy);
      vel_z <= satv(rvz);
    end
  end

  // Round the scaled products
  always_comb begin
    rpx = (s4_px + PW'(16384)) >>> 15;
    rpy = (s4_py + PW'(16384)) >>> 15;
    rpz = (s4_pz + PW'(16384)) >>> 15;
    rvx = (s4_vx + VW'(16384)) >>> 15;
    rvy = (s4_vy + VW'(16384)) >>> 15;
    rvz = (s4_vz + VW'(16384)) >>> 15;
  end
endmodule

>>> rtl/core/spherical_to_cartesian_state_top.sv
`timescale 1ns / 1ps
// 25 register stages (20 CORDIC + 5 product); out_valid rises when the input beat
// that was taken has passed through all of them.
// Throughput: one beat per cycle; the whole pipeline stalls when the output is held.
// Reset clears only the valid chain; data registers are not reset.
module spherical_to_cartesian_state_top import s2c_pkg::*; #(
  parameter int ANGLE_BITS  = 16,
  parameter int RADIUS_BITS = 31,
  parameter int SPEED_BITS  = 23
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ANGLE_BITS-1:0] longitude,
  input  logic signed [ANGLE_BITS-1:0] latitude,
  input  logic [RADIUS_BITS-1:0]       radius,
  input  logic [SPEED_BITS-1:0]        speed,
  input  logic signed [ANGLE_BITS-1:0] flight_path_angle,
  input  logic signed [ANGLE_BITS-1:0] heading,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [RADIUS_BITS:0]  pos_x,
  output logic signed [RADIUS_BITS:0]  pos_y,
  output logic signed [RADIUS_BITS:0]  pos_z,
  output logic signed [SPEED_BITS:0]   vel_x,
  output logic signed [SPEED_BITS:0]   vel_y,
  output logic signed [SPEED_BITS:0]   vel_z
);
  localparam int Depth = CordicSteps + 5;
  localparam int MathDepth = 5;

  logic en;
  logic [Depth-1:0] vld;
  logic [RADIUS_BITS-1:0] r_dly [0:CordicSteps];
  logic [SPEED_BITS-1:0]  v_dly [0:CordicSteps];
  trig_t tt, td, tg, tc;

  // Advance when the output slot is free or being taken
  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign out_valid = vld[Depth-1];

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end

  // Delay radius and speed alongside the CORDIC
  assign r_dly[0] = radius;
  assign v_dly[0] = speed;
  for (genvar i = 0; i < CordicSteps; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        r_dly[i+1] <= r_dly[i];
        v_dly[i+1] <= v_dly[i];
      end
    end
  end

  s2c_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_lon (
    .clk(clk), .en(en), .angle(longitude), .trig(tt));
  s2c_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_lat (
    .clk(clk), .en(en), .angle(latitude), .trig(td));
  s2c_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_fpa (
    .clk(clk), .en(en), .angle(flight_path_angle), .trig(tg));
  s2c_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_hdg (
    .clk(clk), .en(en), .angle(heading), .trig(tc));

  s2c_math #(.RADIUS_BITS(RADIUS_BITS), .SPEED_BITS(SPEED_BITS)) u_math (
    .clk(clk), .en(en), .tt(tt), .td(td), .tg(tg), .tc(tc),
    .radius(r_dly[CordicSteps]), .speed(v_dly[CordicSteps]),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z));

  if (MathDepth + CordicSteps != Depth) begin : g_bad
    $error("depth mismatch");
  end
endmodule

>>> rtl/core/s2c_checker.sv
`timescale 1ns / 1ps
`include "spherical_to_cartesian_state_top_defines.svh"
// Port-level checks on the converter
module s2c_checker #(
  parameter int RADIUS_BITS = 31,
  parameter int SPEED_BITS  = 23
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [RADIUS_BITS:0] pos_z,
  input logic signed [SPEED_BITS:0] vel_z
);
  // A held result keeps its data
  `S2C_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(pos_z) && $stable(vel_z))
  // Input is taken whenever the output is not blocked
  `S2C_ASSERT_IMP(a_ready, !out_valid || out_ready, in_ready)
  // A blocked output blocks the input
  `S2C_ASSERT_IMP(a_stall, out_valid && !out_ready, !in_ready)
  // Nothing comes out right after reset
  `S2C_ASSERT_IMP(a_reset, $fell(rst), !out_valid)
  // Ready is always known while a beat is offered
  `S2C_ASSERT_IMP(a_known, in_valid, !$isunknown(in_ready))
endmodule

bind spherical_to_cartesian_state_top s2c_checker #(
  .RADIUS_BITS(RADIUS_BITS), .SPEED_BITS(SPEED_BITS)) u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .pos_z(pos_z), .vel_z(vel_z));
